@@ src/spq_pkg.sv @@
package spq_pkg;

    // field widths of the word format
    localparam int PRIO_BITS    = 8;
    localparam int PAYLOAD_BITS = 16;
    localparam int STATUS_BITS  = 2;

    // default depth of the queue
    localparam int CAPACITY_DEF = 16;

    typedef enum logic {
        KIND_ENQ = 1'b0,
        KIND_DEQ = 1'b1
    } t_kind;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        t_kind                   kind;
        logic [PRIO_BITS-1:0]    prio_in;
        logic [PAYLOAD_BITS-1:0] payload_in;
    } t_in_word;

    typedef struct packed {
        t_status                 status;
        logic [PRIO_BITS-1:0]    prio_out;
        logic [PAYLOAD_BITS-1:0] payload_out;
    } t_out_word;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic enq;
        logic deq;
        logic report;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        t_kind kind;
        logic  full;
        logic  empty;
    } t_stat;

endpackage

@@ src/sorted_priority_queue.sv @@
// Bounded priority queue held as a sorted row of registers, smallest priority
// number at the head. Issue a word by raising start while busy is low; the
// word is taken at that edge. An enqueue word inserts (prio_in, payload_in)
// ahead of every stored entry of equal or larger priority number, so among
// equal priorities the newest leaves first. A dequeue word removes the head.
// Every word produces exactly one result word, shown on o_result for a single
// cycle with o_valid high, from the result register. The receiver has no way
// to stall it: capture o_result whenever o_valid is high. Status is ok, empty
// (dequeue on an empty queue) or full (enqueue on a full queue, word dropped);
// prio_out and payload_out are zero unless a dequeue succeeded. A word is
// latched, then executed: an enqueue compares all slots against the new
// priority in parallel and shifts by one place, a dequeue shifts every slot
// one place toward the head. busy is high while executing, so no word is taken
// then. No clearing pass is needed after reset; only count, valid, state reset.
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    input  t_in_word  i_cmd,
    output logic      busy,
    output t_out_word o_result,
    output logic      o_valid
);

    // command and status between controller and datapath
    t_cmd  w_cmd;
    t_stat w_stat;

    // sequencer: latch cycle, then execute cycle
    spq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (w_stat),
        .busy    (busy),
        .o_cmd   (w_cmd)
    );

    // sorted slot row, fill count and result register
    spq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_word   (i_cmd),
        .i_cmd    (w_cmd),
        .o_stat   (w_stat),
        .o_result (o_result),
        .o_valid  (o_valid)
    );

endmodule

@@ src/spq_ctrl.sv @@
module spq_ctrl
    import spq_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  start,
    input  t_stat i_stat,
    output logic  busy,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        case (r_state)
            S_IDLE: begin
                n_state = start ? S_EXEC : S_IDLE;
            end
            S_EXEC: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        busy   = 1'b0;
        o_cmd  = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.load = start;
            end
            S_EXEC: begin
                busy         = 1'b1;
                o_cmd.enq    = (i_stat.kind == KIND_ENQ) && !i_stat.full;
                o_cmd.deq    = (i_stat.kind == KIND_DEQ) && !i_stat.empty;
                o_cmd.report = 1'b1;
            end
            default: begin
                busy = 1'b0;
            end
        endcase
    end

endmodule

@@ src/spq_datapath.sv @@
module spq_datapath
    import spq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_word  i_word,
    input  t_cmd      i_cmd,
    output t_stat     o_stat,
    output t_out_word o_result,
    output logic      o_valid
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic [PRIO_BITS-1:0]    r_prio    [CAPACITY];
    logic [PAYLOAD_BITS-1:0] r_payload [CAPACITY];
    logic [PRIO_BITS-1:0]    n_prio    [CAPACITY];
    logic [PAYLOAD_BITS-1:0] n_payload [CAPACITY];
    logic [CW-1:0]           r_count;
    t_in_word                r_word;
    t_out_word               r_result;
    t_out_word               n_result;
    logic                    r_valid;
    logic [CAPACITY-1:0]     w_lt;

    // thermometer of slots that stay ahead of the new entry
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            w_lt[i] = (CW'(i) < r_count) && (r_prio[i] < r_word.prio_in);
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_slot
        always_comb begin
            n_prio[g]    = r_prio[g];
            n_payload[g] = r_payload[g];
            if (i_cmd.enq) begin
                if (!w_lt[g]) begin
                    if (g == 0) begin
                        n_prio[g]    = r_word.prio_in;
                        n_payload[g] = r_word.payload_in;
                    end else if (w_lt[(g == 0) ? 0 : g-1]) begin
                        n_prio[g]    = r_word.prio_in;
                        n_payload[g] = r_word.payload_in;
                    end else begin
                        n_prio[g]    = r_prio[(g == 0) ? 0 : g-1];
                        n_payload[g] = r_payload[(g == 0) ? 0 : g-1];
                    end
                end
            end else if (i_cmd.deq) begin
                if (g != CAPACITY-1) begin
                    n_prio[g]    = r_prio[(g == CAPACITY-1) ? g : g+1];
                    n_payload[g] = r_payload[(g == CAPACITY-1) ? g : g+1];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            r_prio[g]    <= n_prio[g];
            r_payload[g] <= n_payload[g];
        end
    end

    // result word for the operation in the execute cycle
    always_comb begin
        n_result = '0;
        if (r_word.kind == KIND_ENQ) begin
            n_result.status = o_stat.full ? ST_FULL : ST_OK;
        end else if (o_stat.empty) begin
            n_result.status = ST_EMPTY;
        end else begin
            n_result.status      = ST_OK;
            n_result.prio_out    = r_prio[0];
            n_result.payload_out = r_payload[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_word <= i_word;
        end
        if (i_cmd.report) begin
            r_result <= n_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.report;
            if (i_cmd.enq) begin
                r_count <= r_count + 1'b1;
            end else if (i_cmd.deq) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_stat.kind  = r_word.kind;
    assign o_stat.full  = (r_count == CW'(CAPACITY));
    assign o_stat.empty = (r_count == '0);
    assign o_result     = r_result;
    assign o_valid      = r_valid;

endmodule

@@ verif/sorted_priority_queue_tb.sv @@
`timescale 1ns / 1ps

module sorted_priority_queue_tb;
    import spq_pkg::*;

    localparam int CAPACITY   = CAPACITY_DEF;
    localparam int QUIET_MAX  = 2000;   // cycles with no word taken or returned
    localparam int MAX_SHOWN  = 10;
    localparam int RAND_WORDS = 400;

    // one queued word for the driver, optionally held until the queue of
    // awaited results has drained
    typedef struct {
        t_in_word word;
        bit       drain_first;
    } t_stim;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start   = 1'b0;
    t_in_word  i_cmd   = '0;
    logic      busy;
    t_out_word o_result;
    logic      o_valid;

    sorted_priority_queue #(
        .CAPACITY(CAPACITY)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_cmd   (i_cmd),
        .busy    (busy),
        .o_result(o_result),
        .o_valid (o_valid)
    );

    // shadow copy of the sorted row, head at index 0
    logic [PRIO_BITS-1:0]    held_prio    [CAPACITY];
    logic [PAYLOAD_BITS-1:0] held_payload [CAPACITY];
    int                      held_count = 0;

    t_stim     pending_words  [$];
    t_out_word awaited_results[$];

    bit next_start;
    t_in_word next_cmd;
    bit word_taken  = 1'b0;   // set at the rising edge, consumed at the falling edge
    int words_sent  = 0;
    int idle_pct    = 8;
    int quiet_count = 0;
    int fail_count  = 0;
    int gen_fill    = 0;      // rough fill level seen by the stimulus generator

    // expected result of one word, updating the shadow row as the block would
    function automatic t_out_word serve_word(t_in_word w);
        t_out_word r;
        int        pos;
        r.status      = ST_OK;
        r.prio_out    = '0;
        r.payload_out = '0;
        if (w.kind == KIND_ENQ) begin
            if (held_count >= CAPACITY) begin
                // full queue drops the word
                r.status = ST_FULL;
            end else begin
                // insert ahead of the first entry with equal or larger number
                pos = 0;
                while (pos < held_count && held_prio[pos] < w.prio_in)
                    pos++;
                for (int i = held_count; i > pos; i--) begin
                    held_prio[i]    = held_prio[i-1];
                    held_payload[i] = held_payload[i-1];
                end
                held_prio[pos]    = w.prio_in;
                held_payload[pos] = w.payload_in;
                held_count++;
            end
        end else begin
            if (held_count == 0) begin
                r.status = ST_EMPTY;
            end else begin
                r.prio_out    = held_prio[0];
                r.payload_out = held_payload[0];
                for (int i = 1; i < held_count; i++) begin
                    held_prio[i-1]    = held_prio[i];
                    held_payload[i-1] = held_payload[i];
                end
                held_count--;
            end
        end
        return r;
    endfunction

    task automatic add_word(t_kind k, int p, int d, bit drain_first = 1'b0);
        t_stim s;
        s.word.kind       = k;
        s.word.prio_in    = p[PRIO_BITS-1:0];
        s.word.payload_in = d[PAYLOAD_BITS-1:0];
        s.drain_first     = drain_first;
        pending_words.push_back(s);
    endtask

    // priorities cluster on a few values now and then so that ties are common
    function automatic int pick_prio();
        int roll;
        roll = $urandom_range(99);
        if (roll < 40)
            return $urandom_range(3);
        else if (roll < 45)
            return 0;
        else if (roll < 50)
            return (1 << PRIO_BITS) - 1;
        else
            return $urandom_range((1 << PRIO_BITS) - 1);
    endfunction

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // driver: offers the next word at the falling edge, holds it until taken
    always @(negedge i_clk) begin
        next_start = start;
        next_cmd   = i_cmd;
        if (word_taken) begin
            next_start = 1'b0;
            word_taken = 1'b0;
        end
        if (i_rst_n && !next_start) begin
            // idle rate changes as the run goes on: light, then heavy, then none
            if (words_sent < 140)
                idle_pct = 8;
            else if (words_sent < 280)
                idle_pct = 74;
            else
                idle_pct = 0;
            if (pending_words.size() == 0) begin
                next_cmd = t_in_word'($urandom);
            end else if (pending_words[0].drain_first && awaited_results.size() != 0) begin
                // hold off until every outstanding result is back
                next_cmd = t_in_word'($urandom);
            end else if ($urandom_range(99) < idle_pct) begin
                // idle cycle with junk on the command bus
                next_cmd = t_in_word'($urandom);
            end else begin
                next_cmd   = pending_words[0].word;
                next_start = 1'b1;
                void'(pending_words.pop_front());
                words_sent++;
            end
        end
        start <= next_start;
        i_cmd <= next_cmd;
    end

    // monitor: predicts on each taken word, checks each returned word
    always @(posedge i_clk) begin
        t_out_word want;
        bit        moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (start && !busy) begin
                awaited_results.push_back(serve_word(i_cmd));
                word_taken = 1'b1;
                moved      = 1'b1;
            end
            if (o_valid) begin
                moved = 1'b1;
                if (awaited_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_SHOWN)
                        $display("unexpected result word: status %0d prio %0h payload %0h",
                                 o_result.status, o_result.prio_out, o_result.payload_out);
                end else begin
                    want = awaited_results.pop_front();
                    if (o_result.status !== want.status ||
                        o_result.prio_out !== want.prio_out ||
                        o_result.payload_out !== want.payload_out) begin
                        fail_count++;
                        if (fail_count <= MAX_SHOWN)
                            $display({"result mismatch: expected status %0d prio %0h payload %0h,",
                                      " got status %0d prio %0h payload %0h"},
                                     want.status, want.prio_out, want.payload_out,
                                     o_result.status, o_result.prio_out, o_result.payload_out);
                    end
                end
            end
            // watchdog on cycles where nothing moves in either direction
            if (moved)
                quiet_count = 0;
            else
                quiet_count++;
            if (quiet_count >= QUIET_MAX) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        int mode;
        int roll;
        t_kind k;

        // directed: dequeue on empty, field extremes
        add_word(KIND_DEQ, 0, 0);
        add_word(KIND_ENQ, 0, 16'h0000);
        add_word(KIND_ENQ, (1 << PRIO_BITS) - 1, 16'hffff);
        // tie with the head goes to the front
        add_word(KIND_ENQ, 0, 16'h1234);
        // tie in the middle of the row
        add_word(KIND_ENQ, 128, 16'ha5a5);
        add_word(KIND_ENQ, 128, 16'h5a5a);
        add_word(KIND_DEQ, 0, 0);
        // fill to capacity, then one enqueue that must be dropped
        for (int i = 0; i < CAPACITY - 4; i++)
            add_word(KIND_ENQ, pick_prio(), $urandom_range(16'hffff));
        add_word(KIND_ENQ, 7, 16'hbeef);
        add_word(KIND_DEQ, 0, 0);
        add_word(KIND_DEQ, 0, 0);
        gen_fill = CAPACITY - 2;

        // random: runs of fill-heavy, drain-heavy and balanced traffic so the
        // queue swings between empty and full again and again
        mode = 0;
        for (int n = 0; n < RAND_WORDS; n++) begin
            if (n % 20 == 0)
                mode = $urandom_range(2);
            roll = $urandom_range(99);
            case (mode)
                0: k = (roll < 80) ? KIND_ENQ : KIND_DEQ;
                1: k = (roll < 80) ? KIND_DEQ : KIND_ENQ;
                default: k = (roll < 50) ? KIND_ENQ : KIND_DEQ;
            endcase
            // keep pushing against the full and empty walls only briefly
            if (k == KIND_ENQ && gen_fill >= CAPACITY && roll < 60)
                k = KIND_DEQ;
            else if (k == KIND_DEQ && gen_fill == 0 && roll < 60)
                k = KIND_ENQ;
            if (k == KIND_ENQ && gen_fill < CAPACITY)
                gen_fill++;
            else if (k == KIND_DEQ && gen_fill > 0)
                gen_fill--;
            add_word(k, pick_prio(), $urandom_range(16'hffff),
                     n == 0 || n == 150 || n == 320);
        end

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // all stimulus taken, then all results back, then a short tail
        while (pending_words.size() != 0 || start)
            @(posedge i_clk);
        while (awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);

        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

@@ files.f @@
src/spq_pkg.sv
src/spq_ctrl.sv
src/spq_datapath.sv
src/sorted_priority_queue.sv
verif/sorted_priority_queue_tb.sv
